[rtl/source_tokenizer_macros.svh]
// assertion macros for the checker file
`ifndef SOURCE_TOKENIZER_MACROS_SVH
`define SOURCE_TOKENIZER_MACROS_SVH

// checked only outside reset
`define ST_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) expr) else $error(msg);

// checked at every edge, reset included
`define ST_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) expr) else $error(msg);

`endif

[rtl/stok_pkg.sv]
package stok_pkg;

   localparam int unsigned MAX_RESULTS = 3;
   localparam int unsigned COUNT_BITS  = $clog2(MAX_RESULTS + 1);
   localparam int unsigned FIFO_DEPTH  = 2;

   // token kinds
   localparam logic [4:0] KIND_IF       = 5'd0;
   localparam logic [4:0] KIND_LET      = 5'd1;
   localparam logic [4:0] KIND_ELSE     = 5'd2;
   localparam logic [4:0] KIND_LOOP     = 5'd3;
   localparam logic [4:0] KIND_RETURN   = 5'd4;
   localparam logic [4:0] KIND_GT       = 5'd5;
   localparam logic [4:0] KIND_DOLLAR   = 5'd6;
   localparam logic [4:0] KIND_COMMA    = 5'd7;
   localparam logic [4:0] KIND_LPAREN   = 5'd8;
   localparam logic [4:0] KIND_RPAREN   = 5'd9;
   localparam logic [4:0] KIND_LBRACKET = 5'd10;
   localparam logic [4:0] KIND_RBRACKET = 5'd11;
   localparam logic [4:0] KIND_LBRACE   = 5'd12;
   localparam logic [4:0] KIND_RBRACE   = 5'd13;
   localparam logic [4:0] KIND_NUM      = 5'd14;
   localparam logic [4:0] KIND_STRING   = 5'd15;
   localparam logic [4:0] KIND_PLUS     = 5'd16;
   localparam logic [4:0] KIND_MINUS    = 5'd17;
   localparam logic [4:0] KIND_EQUAL    = 5'd18;
   localparam logic [4:0] KIND_NAME     = 5'd19;
   localparam logic [4:0] KIND_END      = 5'd20;
   localparam logic [4:0] KIND_ERROR    = 5'd21;

   // keyword slots, same order as the keyword kinds
   localparam int unsigned NUM_KEYWORDS = 5;
   localparam logic [2:0] KW_IF     = 3'd0;
   localparam logic [2:0] KW_LET    = 3'd1;
   localparam logic [2:0] KW_ELSE   = 3'd2;
   localparam logic [2:0] KW_LOOP   = 3'd3;
   localparam logic [2:0] KW_RETURN = 3'd4;

   // characters
   localparam logic [7:0] CH_SPACE    = " ";
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_QUOTE    = 8'h22;
   localparam logic [7:0] CH_GT       = ">";
   localparam logic [7:0] CH_DOLLAR   = "$";
   localparam logic [7:0] CH_COMMA    = ",";
   localparam logic [7:0] CH_LPAREN   = "(";
   localparam logic [7:0] CH_RPAREN   = ")";
   localparam logic [7:0] CH_LBRACKET = "[";
   localparam logic [7:0] CH_RBRACKET = "]";
   localparam logic [7:0] CH_LBRACE   = "{";
   localparam logic [7:0] CH_RBRACE   = "}";
   localparam logic [7:0] CH_PLUS     = "+";
   localparam logic [7:0] CH_MINUS    = "-";
   localparam logic [7:0] CH_EQUAL    = "=";

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } req_word_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [15:0] token_line;
      logic [15:0] token_column;
      logic [15:0] token_offset;
      logic [15:0] token_length;
      logic        last_of_run;
   } rsp_word_type;

   // all results caused by one input byte
   typedef struct packed {
      rsp_word_type [MAX_RESULTS-1:0] slot;
      logic [COUNT_BITS-1:0]          count;
   } bundle_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } fifo_status_type;

   typedef struct packed {
      logic       hit;
      logic [4:0] kind;
   } punct_type;

   function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] pos);
      logic [47:0] text;
      case (k)
         KW_IF:     text = {"if", 32'h0};
         KW_LET:    text = {"let", 24'h0};
         KW_ELSE:   text = {"else", 16'h0};
         KW_LOOP:   text = {"loop", 16'h0};
         KW_RETURN: text = "return";
         default:   text = '0;
      endcase
      return text[47 - 8 * pos -: 8];
   endfunction

   function automatic logic [2:0] kw_len(input logic [2:0] k);
      logic [2:0] len;
      case (k)
         KW_IF:     len = 3'd2;
         KW_LET:    len = 3'd3;
         KW_ELSE:   len = 3'd4;
         KW_LOOP:   len = 3'd4;
         KW_RETURN: len = 3'd6;
         default:   len = 3'd0;
      endcase
      return len;
   endfunction

   function automatic punct_type punct_kind(input logic [7:0] b);
      punct_type p;
      p.hit = 1'b1;
      case (b)
         CH_GT:       p.kind = KIND_GT;
         CH_DOLLAR:   p.kind = KIND_DOLLAR;
         CH_COMMA:    p.kind = KIND_COMMA;
         CH_LPAREN:   p.kind = KIND_LPAREN;
         CH_RPAREN:   p.kind = KIND_RPAREN;
         CH_LBRACKET: p.kind = KIND_LBRACKET;
         CH_RBRACKET: p.kind = KIND_RBRACKET;
         CH_LBRACE:   p.kind = KIND_LBRACE;
         CH_RBRACE:   p.kind = KIND_RBRACE;
         CH_PLUS:     p.kind = KIND_PLUS;
         CH_MINUS:    p.kind = KIND_MINUS;
         CH_EQUAL:    p.kind = KIND_EQUAL;
         default: begin
            p.hit  = 1'b0;
            p.kind = KIND_ERROR;
         end
      endcase
      return p;
   endfunction

endpackage

[rtl/stok_scan.sv]
module stok_scan #(
   parameter int unsigned POSITION_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  stok_pkg::req_word_type req_word,
   output logic                  push,
   output stok_pkg::bundle_type  bundle
);
   import stok_pkg::*;

   typedef enum logic [1:0] {MODE_IDLE, MODE_NUM, MODE_NAME, MODE_STR} mode_type;
   typedef logic [POSITION_BITS-1:0] pos_type;

   localparam pos_type POS_MAX = '1;
   localparam pos_type POS_ONE = pos_type'(1);

   mode_type mode_ff, mode_in;
   logic [NUM_KEYWORDS-1:0] cand_ff, cand_in;
   logic [2:0] mpos_ff, mpos_in;
   pos_type line_ff, line_in, col_ff, col_in, off_ff, off_in;
   pos_type sline_ff, sline_in, scol_ff, scol_in, soff_ff, soff_in;
   pos_type tlen_ff, tlen_in;

   rsp_word_type [MAX_RESULTS-1:0] slots;
   logic [COUNT_BITS-1:0] cnt;
   logic [7:0] b;
   logic eoi, consumed, newline, hit_any, is_digit, is_alpha;
   logic [2:0] hit_k;
   logic [NUM_KEYWORDS-1:0] next_cand, first_cand;
   punct_type pk;

   function automatic pos_type sat_inc(input pos_type v);
      return (v == POS_MAX) ? v : v + POS_ONE;
   endfunction

   function automatic rsp_word_type make_rsp(input logic [4:0] kind, input pos_type ln,
                                            input pos_type cl, input pos_type of,
                                            input pos_type len);
      rsp_word_type r;
      r.token_kind   = kind;
      r.token_line   = 16'(ln);
      r.token_column = 16'(cl);
      r.token_offset = 16'(of);
      r.token_length = 16'(len);
      r.last_of_run  = 1'b0;
      return r;
   endfunction

   always_comb begin
      mode_in  = mode_ff;
      cand_in  = cand_ff;
      mpos_in  = mpos_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      off_in   = off_ff;
      sline_in = sline_ff;
      scol_in  = scol_ff;
      soff_in  = soff_ff;
      tlen_in  = tlen_ff;
      slots    = '0;
      cnt      = '0;
      consumed = 1'b0;
      newline  = 1'b0;
      hit_any  = 1'b0;
      hit_k    = '0;
      next_cand  = '0;
      first_cand = '0;
      b   = req_word.in_byte;
      eoi = req_word.end_of_input;
      is_digit = b inside {["0":"9"]};
      is_alpha = b inside {["a":"z"], ["A":"Z"]};
      pk  = punct_kind(b);

      case (mode_ff)
         MODE_NUM: begin
            if (is_digit) begin
               tlen_in  = sat_inc(tlen_ff);
               consumed = 1'b1;
            end else begin
               slots[cnt] = make_rsp(KIND_NUM, sline_in, scol_in, soff_in, tlen_in);
               cnt = cnt + COUNT_BITS'(1);
               mode_in = MODE_IDLE;
            end
         end
         MODE_NAME: begin
            if (cand_ff != '0) begin
               for (int k = 0; k < NUM_KEYWORDS; k++) begin
                  if (cand_ff[k] && mpos_ff < kw_len(3'(k)) &&
                      kw_char(3'(k), mpos_ff) == b) begin
                     if ({1'b0, mpos_ff} + 4'd1 == {1'b0, kw_len(3'(k))}) begin
                        hit_any = 1'b1;
                        hit_k   = 3'(k);
                     end else begin
                        next_cand[k] = 1'b1;
                     end
                  end
               end
               if (hit_any) begin
                  // keyword kinds share the keyword slot numbers
                  slots[cnt] = make_rsp(5'(hit_k), sline_in, scol_in, soff_in, '0);
                  cnt = cnt + COUNT_BITS'(1);
                  mode_in  = MODE_IDLE;
                  cand_in  = '0;
                  mpos_in  = '0;
                  consumed = 1'b1;
               end else if (next_cand != '0) begin
                  cand_in  = next_cand;
                  mpos_in  = mpos_ff + 3'd1;
                  tlen_in  = sat_inc(tlen_ff);
                  consumed = 1'b1;
               end else begin
                  cand_in = '0;
                  mpos_in = '0;
               end
            end
            if (!consumed && mode_in == MODE_NAME) begin
               if (is_alpha || is_digit) begin
                  tlen_in  = sat_inc(tlen_in);
                  consumed = 1'b1;
               end else begin
                  slots[cnt] = make_rsp(KIND_NAME, sline_in, scol_in, soff_in, tlen_in);
                  cnt = cnt + COUNT_BITS'(1);
                  mode_in = MODE_IDLE;
               end
            end
         end
         MODE_STR: begin
            if (b == CH_QUOTE) begin
               slots[cnt] = make_rsp(KIND_STRING, sline_in, scol_in, soff_in, tlen_in);
               cnt = cnt + COUNT_BITS'(1);
               mode_in = MODE_IDLE;
            end else begin
               tlen_in = sat_inc(tlen_ff);
            end
            consumed = 1'b1;
         end
         default: begin
         end
      endcase

      // start of a new token
      if (!consumed) begin
         if (b == CH_LF) begin
            newline = 1'b1;
         end else if (b != CH_SPACE && b != CH_TAB) begin
            for (int k = 0; k < NUM_KEYWORDS; k++) begin
               first_cand[k] = (kw_char(3'(k), 3'd0) == b);
            end
            sline_in = line_ff;
            scol_in  = col_ff;
            soff_in  = off_ff;
            tlen_in  = POS_ONE;
            if (first_cand != '0) begin
               mode_in = MODE_NAME;
               cand_in = first_cand;
               mpos_in = 3'd1;
            end else if (pk.hit) begin
               slots[cnt] = make_rsp(pk.kind, line_ff, col_ff, off_ff, '0);
               cnt = cnt + COUNT_BITS'(1);
            end else if (is_digit) begin
               mode_in = MODE_NUM;
            end else if (b == CH_QUOTE) begin
               mode_in = MODE_STR;
               soff_in = sat_inc(off_ff);
               tlen_in = '0;
            end else if (is_alpha) begin
               mode_in = MODE_NAME;
               cand_in = '0;
               mpos_in = '0;
            end else begin
               slots[cnt] = make_rsp(KIND_ERROR, line_ff, col_ff, off_ff, '0);
               cnt = cnt + COUNT_BITS'(1);
            end
         end
      end

      off_in = sat_inc(off_ff);
      if (newline) begin
         line_in = sat_inc(line_ff);
         col_in  = POS_ONE;
      end else begin
         col_in = sat_inc(col_ff);
      end

      if (eoi) begin
         case (mode_in)
            MODE_NUM: begin
               slots[cnt] = make_rsp(KIND_NUM, sline_in, scol_in, soff_in, tlen_in);
               cnt = cnt + COUNT_BITS'(1);
            end
            MODE_NAME: begin
               slots[cnt] = make_rsp(KIND_NAME, sline_in, scol_in, soff_in, tlen_in);
               cnt = cnt + COUNT_BITS'(1);
            end
            MODE_STR: begin
               slots[cnt] = make_rsp(KIND_ERROR, sline_in, scol_in, soff_in, tlen_in);
               cnt = cnt + COUNT_BITS'(1);
            end
            default: begin
            end
         endcase
         slots[cnt] = make_rsp(KIND_END, line_in, col_in, off_in, '0);
         cnt = cnt + COUNT_BITS'(1);
         mode_in  = MODE_IDLE;
         cand_in  = '0;
         mpos_in  = '0;
         line_in  = POS_ONE;
         col_in   = POS_ONE;
         off_in   = '0;
         sline_in = POS_ONE;
         scol_in  = POS_ONE;
         soff_in  = '0;
         tlen_in  = '0;
      end

      if (cnt != '0) begin
         slots[cnt - COUNT_BITS'(1)].last_of_run = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         cand_ff  <= '0;
         mpos_ff  <= '0;
         line_ff  <= POS_ONE;
         col_ff   <= POS_ONE;
         off_ff   <= '0;
         sline_ff <= POS_ONE;
         scol_ff  <= POS_ONE;
         soff_ff  <= '0;
         tlen_ff  <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         cand_ff  <= cand_in;
         mpos_ff  <= mpos_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         off_ff   <= off_in;
         sline_ff <= sline_in;
         scol_ff  <= scol_in;
         soff_ff  <= soff_in;
         tlen_ff  <= tlen_in;
      end
   end

   assign push         = accept && (cnt != '0);
   assign bundle.slot  = slots;
   assign bundle.count = cnt;

endmodule

[rtl/stok_fifo.sv]
module stok_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  stok_pkg::bundle_type     push_word,
   input  logic                     pop,
   output stok_pkg::fifo_status_type status,
   output stok_pkg::bundle_type     head
);
   import stok_pkg::*;

   localparam int unsigned PTR_BITS = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(FIFO_DEPTH - 1);

   bundle_type store_ff [FIFO_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_BITS:0]   count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_BITS'(1);
         end
         count_ff <= count_ff + (PTR_BITS + 1)'(push) - (PTR_BITS + 1)'(pop);
      end
   end

   assign head             = store_ff[rd_ptr_ff];
   assign status.not_empty = (count_ff != '0);
   assign status.full      = (count_ff == (PTR_BITS + 1)'(FIFO_DEPTH));

endmodule

[rtl/stok_emit.sv]
module stok_emit (
   input  logic                      clock,
   input  logic                      reset,
   input  stok_pkg::fifo_status_type status,
   input  stok_pkg::bundle_type      head,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output stok_pkg::rsp_word_type    rsp_word
);
   import stok_pkg::*;

   bundle_type cur_ff;
   logic [COUNT_BITS-1:0] idx_ff;
   logic busy_ff;
   logic take, done;

   assign take = busy_ff && rsp_ready;
   assign done = take && (idx_ff == cur_ff.count - COUNT_BITS'(1));
   assign pop  = status.not_empty && (!busy_ff || done);

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (pop) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else if (done) begin
         busy_ff <= 1'b0;
      end else if (take) begin
         idx_ff <= idx_ff + COUNT_BITS'(1);
      end
   end

   assign rsp_valid = busy_ff;
   assign rsp_word  = cur_ff.slot[idx_ff];

endmodule

[rtl/source_tokenizer.sv]
// Streaming lexer: one source byte per req word, token words out on rsp. A byte is
// taken every cycle while the two-entry queue between the scanner and the emitter
// has room; the scanner updates line, column, offset and keyword match state in the
// same cycle and queues every token the byte causes (up to three). The emitter hands
// out one token per cycle while rsp_ready is high, and the output rate is what limits
// sustained throughput when tokens are dense. Keywords match as prefixes at a token
// start with no word boundary. Positions count in POSITION_BITS bits, saturate at the
// top and are shown as their low 16 bits. The byte marked end_of_input ends with an
// end token and returns all state to reset.
module source_tokenizer #(
   parameter int unsigned POSITION_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  stok_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output stok_pkg::rsp_word_type rsp_word
);
   import stok_pkg::*;

   logic            accept;
   logic            push;
   logic            pop;
   bundle_type      bundle;
   bundle_type      head;
   fifo_status_type status;

   // a full queue is the only thing that holds the source back
   assign req_ready = !status.full;
   assign accept    = req_valid && req_ready;

   // front: scanner state and token classification, one byte per cycle while the queue has room
   stok_scan #(
      .POSITION_BITS(POSITION_BITS)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_word (req_word),
      .push     (push),
      .bundle   (bundle)
   );

   // queue of per-byte token groups, lets each side stall on its own
   stok_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (bundle),
      .pop       (pop),
      .status    (status),
      .head      (head)
   );

   // back: serializes each group onto rsp; the scanner flags the last token of the byte
   stok_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

[rtl/stok_checker.sv]
`include "source_tokenizer_macros.svh"

module stok_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input stok_pkg::req_word_type req_word,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input stok_pkg::rsp_word_type rsp_word
);
   import stok_pkg::*;

   // stalled token stays put
   `ST_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word), "rsp word changed while stalled")

   // out of reset the block is empty and open for input
   `ST_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid && req_ready, "not empty after reset")

   // the end token is always the last of its byte
   `ST_ASSERT(a_end_last, rsp_valid && rsp_word.token_kind == KIND_END |-> rsp_word.last_of_run, "end token not last")

   // only text tokens carry a length
   `ST_ASSERT(a_zero_len, rsp_valid && rsp_word.token_kind != KIND_NUM && rsp_word.token_kind != KIND_STRING && rsp_word.token_kind != KIND_NAME && rsp_word.token_kind != KIND_ERROR |-> rsp_word.token_length == 16'd0, "length on a non-text token")

endmodule

bind source_tokenizer stok_checker u_checker (.*);
